// ===== hw/rtl/gls_pkg.sv =====
// Package for the sound-log command sequencer: command and result codes,
// parse and control state types, register indexes and reset values.
// No dependencies.
`default_nettype none

package gls_pkg;

   localparam int unsigned DAC_DEPTH_DEF = 63;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 11;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0] FRAME_LEN_RESET = 11'd735;
   localparam logic             FM_ENABLE_RESET = 1'b1;

   // Command bytes.
   localparam logic [BYTE_W-1:0] CMD_END  = 8'd0;
   localparam logic [BYTE_W-1:0] CMD_P1   = 8'd1;
   localparam logic [BYTE_W-1:0] CMD_P2   = 8'd2;
   localparam logic [BYTE_W-1:0] CMD_TONE = 8'd3;

   // Part I address that feeds the DAC buffer instead of the FM chip.
   localparam logic [BYTE_W-1:0] DAC_ADDR = 8'h2A;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_FM    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DAC   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FRAME = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FM_ENABLE = 1'b1;

   typedef enum logic [2:0] {
      PH_CMD,
      PH_P1_ADDR,
      PH_P1_DATA,
      PH_DAC,
      PH_P2_ADDR,
      PH_P2_DATA,
      PH_TONE
   } phase_type;

   typedef enum logic [1:0] {
      CTL_ACCEPT,
      CTL_DIV_START,
      CTL_DIV,
      CTL_FRAME_END
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gls_if.sv =====
// Channel interfaces of the sound-log command sequencer: log byte requests,
// results and configuration writes. Depends on gls_pkg.
`default_nettype none

interface gls_req_if
   import gls_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] log_byte;

   modport source (output valid, output log_byte, input ready);
   modport sink   (input valid, input log_byte, output ready);
endinterface

interface gls_rsp_if
   import gls_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              fm_part;
   logic [BYTE_W-1:0] reg_addr;
   logic [BYTE_W-1:0] reg_data;
   logic [LEN_W-1:0]  dac_offset;
   logic [LEN_W-1:0]  dac_length;
   logic              dac_overflow;
   logic              last;

   modport source (output valid, output kind, output fm_part, output reg_addr,
                   output reg_data, output dac_offset, output dac_length,
                   output dac_overflow, output last, input ready);
   modport sink   (input valid, input kind, input fm_part, input reg_addr,
                   input reg_data, input dac_offset, input dac_length,
                   input dac_overflow, input last, output ready);
endinterface

interface gls_csr_if
   import gls_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LEN_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gls_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 63,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gls_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all DAC samples
// of a frame. No dependencies.
`default_nettype none

module gls_div #(
   parameter int unsigned DW = 17,
   parameter int unsigned VW = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               valid,
   output logic      [DW-1:0] quotient
);

   localparam int unsigned CNTW = $clog2(DW + 1);

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            valid_ff, valid_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW-1:0]   div_ff, div_in;
   logic [VW:0]     trial;
   logic [VW:0]     diff;
   logic            ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         cnt_in   = CNTW'(DW);
         valid_in = 1'b0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNTW'(1);
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         if (cnt_ff == CNTW'(1)) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign valid    = valid_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gym_log_command_sequencer_unit.sv =====
// Top level of the sound-log command sequencer: byte parser, DAC sample
// buffer and frame-end sequencer. Depends on gls_pkg, gls_if, gls_ram, gls_div.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   log_byte
//   rsp_ch   out  valid/ready   kind, fm_part, reg_addr, reg_data, dac_offset,
//                               dac_length, dac_overflow, last
//   csr_ch   in   valid/ready   index, wdata (frame_len, fm_enable)
//
// Results leave through one output register, and a request is taken while
// that register is empty or draining. At frame end, with FM output on, the
// bit-serial divider works out the span of each buffered sample in turn from
// a dividend of PW bits (PW being 17 at a depth of 63); the frame-end result
// follows the last sample. Reset is synchronous; the DAC buffer needs no
// clearing. A stalled result holds the sequencer in place.
`default_nettype none

module gym_log_command_sequencer_unit
   import gls_pkg::*;
#(
   parameter int unsigned DAC_DEPTH = DAC_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   gls_req_if.sink   req_ch,
   gls_rsp_if.source rsp_ch,
   gls_csr_if.sink   csr_ch
);

   localparam int unsigned CW = $clog2(DAC_DEPTH + 1);
   localparam int unsigned AW = (DAC_DEPTH > 1) ? $clog2(DAC_DEPTH) : 1;
   localparam int unsigned PW = CW + LEN_W;

   ctl_type   ctl_ff, ctl_in;
   phase_type phase_ff, phase_in;

   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic [LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic              fm_en_ff, fm_en_in;

   logic              ov_ff, ov_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic              out_part_ff, out_part_in;
   logic [BYTE_W-1:0] out_addr_ff, out_addr_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [LEN_W-1:0]  out_off_ff, out_off_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              req_acc;
   logic              csr_acc;
   logic [BYTE_W-1:0] byte_in;
   logic [CW-1:0]     idx_next;
   logic              last_sample;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_rdata;
   logic              div_start;
   logic              div_valid;
   logic [PW-1:0]     div_dividend;
   logic [PW-1:0]     div_quotient;
   logic [LEN_W-1:0]  q_len;

   assign out_free     = !ov_ff || rsp_ch.ready;
   assign req_ch.ready = (ctl_ff == CTL_ACCEPT) && out_free;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_acc      = csr_ch.valid;
   assign byte_in      = req_ch.log_byte;
   assign idx_next     = idx_ff + CW'(1);
   assign last_sample  = (idx_next == count_ff);
   assign div_start    = (ctl_ff == CTL_DIV_START);
   assign div_dividend = PW'(idx_next) * PW'(frame_len_ff);
   assign q_len        = div_quotient[LEN_W-1:0];

   gls_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DAC_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (byte_in),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   gls_div #(
      .DW (PW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .valid    (div_valid),
      .quotient (div_quotient)
   );

   // Next state of the parser and the frame-end sequencer.
   always_comb begin
      ctl_in   = ctl_ff;
      phase_in = phase_ff;
      case (ctl_ff)
         CTL_ACCEPT: begin
            if (req_acc) begin
               case (phase_ff)
                  PH_CMD: begin
                     if (byte_in == CMD_END) begin
                        ctl_in = (fm_en_ff && count_ff != '0) ? CTL_DIV_START
                                                              : CTL_FRAME_END;
                     end else if (byte_in == CMD_P1) begin
                        phase_in = PH_P1_ADDR;
                     end else if (byte_in == CMD_P2) begin
                        phase_in = PH_P2_ADDR;
                     end else if (byte_in == CMD_TONE) begin
                        phase_in = PH_TONE;
                     end
                  end
                  PH_P1_ADDR: begin
                     phase_in = (byte_in == DAC_ADDR) ? PH_DAC : PH_P1_DATA;
                  end
                  PH_P2_ADDR: begin
                     phase_in = PH_P2_DATA;
                  end
                  default: begin
                     phase_in = PH_CMD;
                  end
               endcase
            end
         end
         CTL_DIV_START: begin
            ctl_in = CTL_DIV;
         end
         CTL_DIV: begin
            if (div_valid && out_free) begin
               ctl_in = last_sample ? CTL_FRAME_END : CTL_DIV_START;
            end
         end
         CTL_FRAME_END: begin
            if (out_free) begin
               ctl_in = CTL_ACCEPT;
            end
         end
         default: begin
            ctl_in = CTL_ACCEPT;
         end
      endcase
   end

   // Datapath, buffer writes, result register and configuration.
   always_comb begin
      addr_in      = addr_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      frame_len_in = frame_len_ff;
      fm_en_in     = fm_en_ff;
      ram_we       = 1'b0;
      ov_in        = ov_ff && !rsp_ch.ready;
      out_kind_in  = out_kind_ff;
      out_part_in  = out_part_ff;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_off_in   = out_off_ff;
      out_len_in   = out_len_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;

      if (csr_acc) begin
         case (csr_ch.index)
            CSR_FRAME_LEN: frame_len_in = csr_ch.wdata;
            CSR_FM_ENABLE: fm_en_in     = csr_ch.wdata[0];
            default: begin
            end
         endcase
      end

      case (ctl_ff)
         CTL_ACCEPT: begin
            if (req_acc) begin
               case (phase_ff)
                  PH_CMD: begin
                     idx_in = '0;
                     off_in = '0;
                  end
                  PH_P1_ADDR, PH_P2_ADDR: begin
                     addr_in = byte_in;
                  end
                  PH_P1_DATA, PH_P2_DATA: begin
                     ov_in       = 1'b1;
                     out_kind_in = KIND_FM;
                     out_part_in = (phase_ff == PH_P2_DATA);
                     out_addr_in = addr_ff;
                     out_data_in = byte_in;
                     out_off_in  = '0;
                     out_len_in  = '0;
                     out_ovf_in  = 1'b0;
                     out_last_in = 1'b1;
                  end
                  PH_TONE: begin
                     ov_in       = 1'b1;
                     out_kind_in = KIND_TONE;
                     out_part_in = 1'b0;
                     out_addr_in = '0;
                     out_data_in = byte_in;
                     out_off_in  = '0;
                     out_len_in  = '0;
                     out_ovf_in  = 1'b0;
                     out_last_in = 1'b1;
                  end
                  PH_DAC: begin
                     if (count_ff < CW'(DAC_DEPTH)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CTL_DIV: begin
            // The quotient is the start of the next sample, so the length
            // of this one is its distance from the current offset.
            if (div_valid && out_free) begin
               ov_in       = 1'b1;
               out_kind_in = KIND_DAC;
               out_part_in = 1'b0;
               out_addr_in = DAC_ADDR;
               out_data_in = ram_rdata;
               out_off_in  = off_ff;
               out_len_in  = q_len - off_ff;
               out_ovf_in  = 1'b0;
               out_last_in = 1'b0;
               off_in      = q_len;
               idx_in      = idx_next;
            end
         end
         CTL_FRAME_END: begin
            if (out_free) begin
               ov_in       = 1'b1;
               out_kind_in = KIND_FRAME;
               out_part_in = 1'b0;
               out_addr_in = '0;
               out_data_in = '0;
               out_off_in  = '0;
               out_len_in  = '0;
               out_ovf_in  = drop_ff;
               out_last_in = 1'b1;
               count_in    = '0;
               drop_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_ACCEPT;
         phase_ff     <= PH_CMD;
         addr_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         frame_len_ff <= FRAME_LEN_RESET;
         fm_en_ff     <= FM_ENABLE_RESET;
         ov_ff        <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         frame_len_ff <= frame_len_in;
         fm_en_ff     <= fm_en_in;
         ov_ff        <= ov_in;
      end
      idx_ff      <= idx_in;
      off_ff      <= off_in;
      out_kind_ff <= out_kind_in;
      out_part_ff <= out_part_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_off_ff  <= out_off_in;
      out_len_ff  <= out_len_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.kind         = out_kind_ff;
   assign rsp_ch.fm_part      = out_part_ff;
   assign rsp_ch.reg_addr     = out_addr_ff;
   assign rsp_ch.reg_data     = out_data_ff;
   assign rsp_ch.dac_offset   = out_off_ff;
   assign rsp_ch.dac_length   = out_len_ff;
   assign rsp_ch.dac_overflow = out_ovf_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gls_checker.sv =====
// Port-level checks for the sound-log command sequencer, bound to the top
// level. Depends on gls_pkg and gym_log_command_sequencer_unit.
`default_nettype none

module gls_checker
   import gls_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [LEN_W-1:0]  rsp_dac_offset,
   input wire logic [LEN_W-1:0]  rsp_dac_length,
   input wire logic              rsp_last
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A new request is never taken while a result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !(rsp_valid && !rsp_ready))
      else $error("request taken over a stalled result");

   // Only DAC samples leave the request unfinished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_DAC)))
      else $error("last flag does not match result kind");

   // Offset and length belong to DAC samples alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DAC |->
         rsp_dac_offset == '0 && rsp_dac_length == '0)
      else $error("offset or length set on a non-DAC result");

endmodule

bind gym_log_command_sequencer_unit gls_checker u_gls_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_dac_offset (rsp_ch.dac_offset),
   .rsp_dac_length (rsp_ch.dac_length),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sound-log command sequencer.
// Drives log byte requests and register writes, predicts every result and checks them in order.
// Depends on gls_pkg, gls_if and gym_log_command_sequencer_unit.

module tb_top
   import gls_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned SETTLE_TICKS = 8;
   localparam int unsigned DRAIN_TICKS  = 40;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned STREAM_BYTES = 90;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              fm_part;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] reg_data;
      logic [LEN_W-1:0]  dac_offset;
      logic [LEN_W-1:0]  dac_length;
      logic              dac_overflow;
      logic              last;
   } log_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gls_req_if req_ch ();
   gls_rsp_if rsp_ch ();
   gls_csr_if csr_ch ();

   gym_log_command_sequencer_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the sequencer state and its registers.
   logic [LEN_W-1:0]  frame_len_q = FRAME_LEN_RESET;
   logic              fm_enable_q = FM_ENABLE_RESET;
   phase_type         parse_phase = PH_CMD;
   logic [BYTE_W-1:0] held_addr   = '0;
   logic [BYTE_W-1:0] dac_samples [DAC_DEPTH_DEF];
   int unsigned       dac_held    = 0;
   logic              dac_dropped = 1'b0;

   log_result_type expected_results [$];

   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;

   int unsigned bytes_taken    = 0;
   int unsigned results_seen   = 0;
   int unsigned samples_seen   = 0;
   int unsigned frames_seen    = 0;
   int unsigned overflow_seen  = 0;
   int unsigned failures       = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void push_result(input logic [KIND_W-1:0] kind, input logic part,
                                       input logic [BYTE_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [LEN_W-1:0] offset,
                                       input logic [LEN_W-1:0] length,
                                       input logic overflow, input logic last);
      log_result_type r;
      r.kind         = kind;
      r.fm_part      = part;
      r.reg_addr     = addr;
      r.reg_data     = data;
      r.dac_offset   = offset;
      r.dac_length   = length;
      r.dac_overflow = overflow;
      r.last         = last;
      expected_results.push_back(r);
   endfunction

   // Frame end: with FM output on, spread the buffered samples over the frame
   // with exact floors, the last one running to the frame end; then report the overflow flag.
   function automatic void close_frame();
      int unsigned i;
      int unsigned n;
      int unsigned start;
      int unsigned stop;
      n = dac_held;
      if (fm_enable_q && n != 0) begin
         for (i = 0; i < n; i++) begin
            start = (i * frame_len_q) / n;
            stop  = (i + 1 == n) ? frame_len_q : ((i + 1) * frame_len_q) / n;
            push_result(KIND_DAC, 1'b0, DAC_ADDR, dac_samples[i], LEN_W'(start),
                        LEN_W'(stop - start), 1'b0, 1'b0);
         end
      end
      push_result(KIND_FRAME, 1'b0, '0, '0, '0, '0, dac_dropped, 1'b1);
      dac_held    = 0;
      dac_dropped = 1'b0;
   endfunction

   function automatic void predict_log_byte(input logic [BYTE_W-1:0] b);
      case (parse_phase)
         PH_CMD: begin
            if (b == CMD_END) close_frame();
            else if (b == CMD_P1) parse_phase = PH_P1_ADDR;
            else if (b == CMD_P2) parse_phase = PH_P2_ADDR;
            else if (b == CMD_TONE) parse_phase = PH_TONE;
         end
         PH_P1_ADDR: begin
            held_addr   = b;
            parse_phase = (b == DAC_ADDR) ? PH_DAC : PH_P1_DATA;
         end
         PH_P1_DATA: begin
            push_result(KIND_FM, 1'b0, held_addr, b, '0, '0, 1'b0, 1'b1);
            parse_phase = PH_CMD;
         end
         PH_DAC: begin
            if (dac_held < DAC_DEPTH_DEF) begin
               dac_samples[dac_held] = b;
               dac_held++;
            end else begin
               dac_dropped = 1'b1;
            end
            parse_phase = PH_CMD;
         end
         PH_P2_ADDR: begin
            held_addr   = b;
            parse_phase = PH_P2_DATA;
         end
         PH_P2_DATA: begin
            push_result(KIND_FM, 1'b1, held_addr, b, '0, '0, 1'b0, 1'b1);
            parse_phase = PH_CMD;
         end
         PH_TONE: begin
            push_result(KIND_TONE, 1'b0, '0, b, '0, '0, 1'b0, 1'b1);
            parse_phase = PH_CMD;
         end
         default: parse_phase = PH_CMD;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   function automatic void check_result();
      log_result_type want;
      if (expected_results.size() == 0) begin
         failures++;
         $display("%0t: unexpected result, kind %0d data 0x%0h", $time, rsp_ch.kind,
                  rsp_ch.reg_data);
         return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (want.kind == KIND_DAC) samples_seen++;
      if (want.kind == KIND_FRAME) frames_seen++;
      if (want.dac_overflow) overflow_seen++;
      check_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
      check_field("fm_part", 16'(want.fm_part), 16'(rsp_ch.fm_part));
      check_field("reg_addr", 16'(want.reg_addr), 16'(rsp_ch.reg_addr));
      check_field("reg_data", 16'(want.reg_data), 16'(rsp_ch.reg_data));
      check_field("dac_offset", 16'(want.dac_offset), 16'(rsp_ch.dac_offset));
      check_field("dac_length", 16'(want.dac_length), 16'(rsp_ch.dac_length));
      check_field("dac_overflow", 16'(want.dac_overflow), 16'(rsp_ch.dac_overflow));
      check_field("last", 16'(want.last), 16'(rsp_ch.last));
   endfunction

   // Register writes are applied before the request of the same edge, which
   // cannot happen anyway since registers are only written while idle.
   always @(posedge clock) begin
      if (reset) begin
         parse_phase = PH_CMD;
         held_addr   = '0;
         dac_held    = 0;
         dac_dropped = 1'b0;
         frame_len_q = FRAME_LEN_RESET;
         fm_enable_q = FM_ENABLE_RESET;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_FRAME_LEN) frame_len_q = csr_ch.wdata;
            else if (csr_ch.index == CSR_FM_ENABLE) fm_enable_q = csr_ch.wdata[0];
         end
         if (req_ch.valid && req_ch.ready) begin
            bytes_taken++;
            predict_log_byte(req_ch.log_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, expected_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Leaves valid high after the request is taken so that back-to-back
   // requests need no extra edge; drain() lowers it.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_ch.valid    <= 1'b1;
      req_ch.log_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_fm(input logic part, input logic [BYTE_W-1:0] addr,
                          input logic [BYTE_W-1:0] data);
      send_byte(part ? CMD_P2 : CMD_P1);
      send_byte(addr);
      send_byte(data);
   endtask

   task automatic send_tone(input logic [BYTE_W-1:0] data);
      send_byte(CMD_TONE);
      send_byte(data);
   endtask

   task automatic send_frame(input int unsigned samples);
      repeat (samples) send_fm(1'b0, DAC_ADDR, BYTE_W'($urandom_range(255)));
      send_byte(CMD_END);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [LEN_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [LEN_W-1:0] frame_len, input logic fm_enable);
      drain();
      write_csr(CSR_FRAME_LEN, frame_len);
      write_csr(CSR_FM_ENABLE, LEN_W'(fm_enable));
   endtask

   function automatic logic [LEN_W-1:0] pick_frame_len();
      case ($urandom_range(5))
         0: return '0;
         1: return LEN_W'(1);
         2: return '1;
         3: return LEN_W'($urandom_range(64, 1));
         default: return LEN_W'($urandom_range(2047, 1));
      endcase
   endfunction

   // Mostly well-formed commands with random content, some noise that can
   // break a command apart, and the odd short frame of DAC samples.
   task automatic send_random_command();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 34) begin
         send_fm(1'b0, DAC_ADDR, BYTE_W'($urandom_range(255)));
      end else if (pick < 52) begin
         send_fm(1'b0, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      end else if (pick < 67) begin
         send_fm(1'b1, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      end else if (pick < 79) begin
         send_tone(BYTE_W'($urandom_range(255)));
      end else if (pick < 88) begin
         send_byte(CMD_END);
         if ($urandom_range(3) == 0) configure(pick_frame_len(), $urandom_range(3) != 0);
      end else if (pick < 93) begin
         send_byte(BYTE_W'($urandom_range(255, 4)));
      end else if (pick < 99) begin
         send_byte(BYTE_W'($urandom_range(255)));
      end else begin
         send_frame($urandom_range(12, 2));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_commands();
      send_tone(8'h00);
      send_tone(8'hFF);
      send_fm(1'b0, 8'h00, 8'hFF);
      send_fm(1'b0, 8'hFF, 8'h00);
      send_fm(1'b1, DAC_ADDR, 8'h00);
      send_byte(8'h04);
      send_byte(8'hFF);
      send_byte(CMD_END);
      send_fm(1'b0, DAC_ADDR, 8'h00);
      send_fm(1'b0, DAC_ADDR, 8'hFF);
      send_fm(1'b0, DAC_ADDR, 8'h81);
      send_byte(CMD_END);
      drain();
   endtask

   task automatic test_frame_length_extremes();
      configure('0, 1'b1);
      send_frame(3);
      configure(LEN_W'(1), 1'b1);
      send_frame(5);
      configure('1, 1'b1);
      send_frame(7);
      send_frame(1);
      configure(FRAME_LEN_RESET, 1'b0);
      send_frame(4);
      configure(FRAME_LEN_RESET, FM_ENABLE_RESET);
   endtask

   task automatic test_dac_overflow();
      configure('1, 1'b1);
      repeat (DAC_DEPTH_DEF + 2) begin
         send_fm(1'b0, DAC_ADDR, BYTE_W'($urandom_range(255)));
         if ($urandom_range(7) == 0) send_tone(BYTE_W'($urandom_range(255)));
      end
      send_byte(CMD_END);
      // The flag must be clear again on the next, empty frame.
      send_byte(CMD_END);
      configure(FRAME_LEN_RESET, FM_ENABLE_RESET);
   endtask

   // The receiver holds off while requests keep coming, so the block backs
   // up and stalls its input; then the sender waits for every result.
   task automatic test_long_stall();
      int unsigned saved_gap;
      saved_gap = send_gap_pct;
      drain();
      send_gap_pct = 0;
      hold_left <= LONG_HOLD;
      repeat (10) begin
         send_tone(BYTE_W'($urandom_range(255)));
         send_fm(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                 BYTE_W'($urandom_range(255)));
      end
      send_frame(5);
      drain();
      send_gap_pct = saved_gap;
   endtask

   task automatic test_random_stream();
      int unsigned phase;
      int unsigned goal;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_gap_pct = 28; rsp_stall_pct = 86; end
            1: begin send_gap_pct = 86; rsp_stall_pct = 28; end
            default: begin send_gap_pct = 0; rsp_stall_pct = 0; end
         endcase
         goal = bytes_taken + STREAM_BYTES / 3;
         while (bytes_taken < goal) send_random_command();
      end
      drain();
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.log_byte = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_FRAME_LEN;
      csr_ch.wdata    = '0;
      rsp_ch.ready    = 1'b0;
      send_gap_pct    = 28;
      rsp_stall_pct   = 86;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_frame_length_extremes();
      test_dac_overflow();
      test_long_stall();
      test_random_stream();

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      $display("Sent %0d log bytes; checked %0d results: %0d DAC samples, %0d frame ends,",
               bytes_taken, results_seen, samples_seen, frames_seen);
      $display("%0d with overflow. Frame lengths from 0 to 2047, FM output on and off,",
               overflow_seen);
      $display("full buffer and long output stalls.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", failures);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== gym_log_command_sequencer_unit.f =====
hw/rtl/gls_pkg.sv
hw/rtl/gls_if.sv
hw/rtl/gls_ram.sv
hw/rtl/gls_div.sv
hw/rtl/gym_log_command_sequencer_unit.sv
hw/rtl/gls_checker.sv
verif/tb_top.sv
